/* design/rtc_pkg.sv */
// shared constants and types for the row trapezoid centroid block
package rtc_pkg;

  // fixed point and geometry
  localparam int FRAC_BITS = 4;
  localparam int SCALE     = 1 << FRAC_BITS;
  localparam int MAX_WIDTH = 2048;

  // field widths
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 13;
  localparam int POS_W  = 16;
  localparam int IMGW_W = 12;
  localparam int IMGH_W = 13;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [IMGW_W-1:0] IMGW_RESET = 12'd2048;
  localparam logic [IMGH_W-1:0] IMGH_RESET = 13'd1024;

  // stream words
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // column counter and clamped positions
  localparam int COL_W  = 12;
  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam int IDX_W  = $clog2(MAX_WIDTH);
  localparam int CPOS_W = IDX_W + FRAC_BITS;

  // accumulators
  localparam int AREA_W = 32;
  localparam int MOM_W  = 48;

  // row job queue between accumulation and division
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);

  // divider
  localparam int DVS_W     = AREA_W + 1;
  localparam int DIV_CNT_W = $clog2(MOM_W);

  // one finished row, ready for the back end
  typedef struct packed {
    logic              fb;
    logic [POS_W-1:0]  val;
    logic [AREA_W-1:0] area;
    logic [MOM_W-1:0]  mom;
  } rtc_job_t;

endpackage

/* design/rtc_front.sv */
// front end: pixel intake, bound latching and pipelined trapezoid accumulation
module rtc_front import rtc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IMGW_W-1:0]  image_width,
  input  logic [IMGH_W-1:0]  image_height,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   pixel,
  input  logic [ROW_W-1:0]   row_index,
  input  logic [POS_W-1:0]   left_bound,
  input  logic [POS_W-1:0]   right_bound,
  input  logic               last_pixel,
  input  logic               slot_free,
  output logic               push,
  output rtc_job_t           push_job
);

  localparam int SUM_W = PIX_W + FRAC_BITS + 1;
  localparam int A_W   = SUM_W + FRAC_BITS + 1;
  localparam int SF_W  = PIX_W + 1;
  localparam int ODD_W = COL_W + 1;
  localparam int FF_W  = SF_W + ODD_W;
  localparam int ML_W  = A_W + POS_W;
  localparam int MF_W  = FF_W + 3 * FRAC_BITS;
  localparam int TS_W  = SUM_W + 2;

  // fallback data that travels with the last word of a row
  typedef struct packed {
    logic             force_fb;
    logic [POS_W-1:0] fb_val;
    logic [POS_W-1:0] zmid;
  } rtc_fb_t;

  function automatic logic [CPOS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] x,
                                                  input logic [CPOS_W-1:0] lim);
    logic signed [POS_W:0] xs;
    logic signed [POS_W:0] ls;
    xs = {x[POS_W-1], x};
    ls = $signed({{(POS_W + 1 - CPOS_W){1'b0}}, lim});
    if (xs < 0) begin
      clamp_pos = '0;
    end else if (xs > ls) begin
      clamp_pos = lim;
    end else begin
      clamp_pos = x[CPOS_W-1:0];
    end
  endfunction

  logic               acc;
  logic               first;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [PIX_W-1:0]   prev_r;
  logic [CNT_W-1:0]   credit_r, credit_nxt;

  // row setup values
  logic [COL_W-1:0]          ew;
  logic [IDX_W-1:0]          wm1;
  logic [CPOS_W-1:0]         lim;
  logic signed [POS_W-1:0]   lb, rb, lo_raw, hi_raw;
  logic [CPOS_W-1:0]         lo_c, hi_c;
  logic [IDX_W-1:0]          il_c, ir_c;
  logic [FRAC_BITS-1:0]      fl_c, fr_c;
  logic                      lok_c, rok_c, row_ok_c;
  logic [POS_W-1:0]          posl_c, posr_c;
  logic [POS_W:0]            rsum;
  logic [CPOS_W:0]           csum;
  rtc_fb_t                   fb_c, fb_row;

  // latched row values
  logic [IDX_W-1:0]     il_r, ir_r;
  logic [FRAC_BITS-1:0] fl_r, fr_r;
  logic                 lok_r, rok_r;
  logic [POS_W-1:0]     posl_r, posr_r;
  rtc_fb_t              fb_r;

  // interval terms
  logic [COL_W-1:0]          iv;
  logic                      hit_l, hit_f, hit_r;
  logic signed [PIX_W:0]     p0s, p1s;
  logic signed [FRAC_BITS:0] fls, frs;
  logic signed [TS_W-1:0]    sl_t, sr_t;

  // stage a
  logic                 a_v, a_first, a_last, a_hl, a_hf, a_hr;
  logic [SUM_W-1:0]     a_sl, a_sr;
  logic [SF_W-1:0]      a_sf;
  logic [ODD_W-1:0]     a_odd;
  logic [FRAC_BITS:0]   a_kl;
  logic [FRAC_BITS-1:0] a_fr;
  logic [POS_W-1:0]     a_posl, a_posr;
  rtc_fb_t              a_fb;

  // stage b
  logic              b_v, b_first, b_last, b_hl, b_hf, b_hr;
  logic [A_W-1:0]    b_al, b_ar;
  logic [FF_W-1:0]   b_ff;
  logic [SF_W-1:0]   b_sf;
  logic [POS_W-1:0]  b_posl, b_posr;
  rtc_fb_t           b_fb;

  // stage c
  logic             c_v, c_first, c_last;
  logic [A_W-1:0]   c_area_l, c_area_r, c_area_f;
  logic [ML_W-1:0]  c_mom_l, c_mom_r;
  logic [MF_W-1:0]  c_mom_f;
  rtc_fb_t          c_fb;

  // stage d
  logic              d_v, d_first, d_last;
  logic [AREA_W-1:0] d_area;
  logic [MOM_W-1:0]  d_mom;
  rtc_fb_t           d_fb;

  // accumulators
  logic [AREA_W-1:0] area_r, area_nxt;
  logic [MOM_W-1:0]  mom_r, mom_nxt;

  assign in_ready = (credit_r != '0);
  assign acc      = in_valid & in_ready;
  assign first    = (col_r == '0);

  // effective width and clamp limit
  always_comb begin
    if (image_width == '0) begin
      ew = COL_W'(1);
    end else if (image_width > COL_W'(MAX_WIDTH)) begin
      ew = COL_W'(MAX_WIDTH);
    end else begin
      ew = image_width;
    end
  end
  assign wm1 = IDX_W'(ew - 1'b1);
  assign lim = {wm1, {FRAC_BITS{1'b0}}};

  // order and clamp the incoming bounds
  assign lb     = $signed(left_bound);
  assign rb     = $signed(right_bound);
  assign lo_raw = (lb > rb) ? rb : lb;
  assign hi_raw = (lb > rb) ? lb : rb;
  assign lo_c   = clamp_pos(lo_raw, lim);
  assign hi_c   = clamp_pos(hi_raw, lim);
  assign il_c   = lo_c[CPOS_W-1:FRAC_BITS];
  assign fl_c   = lo_c[FRAC_BITS-1:0];
  assign ir_c   = hi_c[CPOS_W-1:FRAC_BITS];
  assign fr_c   = hi_c[FRAC_BITS-1:0];
  assign lok_c  = (il_c < wm1);
  assign rok_c  = (ir_c < wm1);
  assign posl_c = POS_W'(lo_c) + POS_W'({({1'b0, il_c} + 1'b1), {FRAC_BITS{1'b0}}});
  assign posr_c = POS_W'({ir_c, {FRAC_BITS{1'b0}}}) + POS_W'(hi_c);

  // fallback values of the row
  assign row_ok_c = !row_index[ROW_W-1] &&
                    ({1'b0, row_index[ROW_W-2:0]} < image_height);
  assign rsum     = {lb[POS_W-1], lb} + {rb[POS_W-1], rb};
  assign csum     = {1'b0, lo_c} + {1'b0, hi_c};
  always_comb begin
    fb_c.force_fb = !row_ok_c || (lo_c == hi_c);
    fb_c.fb_val   = row_ok_c ? POS_W'(lo_c) : rsum[POS_W:1];
    fb_c.zmid     = POS_W'(csum[CPOS_W:1]);
  end
  assign fb_row = first ? fb_c : fb_r;

  // which terms this interval contributes
  assign iv    = col_r - 1'b1;
  assign hit_l = !first && (iv == COL_W'(il_r)) && lok_r;
  assign hit_f = !first && (iv > COL_W'(il_r)) && (iv < COL_W'(ir_r));
  assign hit_r = !first && (iv == COL_W'(ir_r)) && rok_r;

  // partial trapezoid heights
  assign p0s  = $signed({1'b0, prev_r});
  assign p1s  = $signed({1'b0, pixel});
  assign fls  = $signed({1'b0, fl_r});
  assign frs  = $signed({1'b0, fr_r});
  assign sl_t = ((p0s + p1s) <<< FRAC_BITS) + (p1s - p0s) * fls;
  assign sr_t = (p0s <<< (FRAC_BITS + 1)) + (p1s - p0s) * frs;

  // credit for queue slots, one per row end in flight
  always_comb begin
    credit_nxt = credit_r;
    if ((acc && last_pixel) && !slot_free) begin
      credit_nxt = credit_r - 1'b1;
    end else if (!(acc && last_pixel) && slot_free) begin
      credit_nxt = credit_r + 1'b1;
    end
  end

  // column counter
  always_comb begin
    col_nxt = col_r;
    if (acc) begin
      if (last_pixel) begin
        col_nxt = '0;
      end else if (col_r != COL_MAX) begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= CNT_W'(Q_DEPTH);
      col_r    <= '0;
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      c_v      <= 1'b0;
      d_v      <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      col_r    <= col_nxt;
      a_v      <= acc;
      b_v      <= a_v;
      c_v      <= b_v;
      d_v      <= c_v;
    end
  end

  // row latch and previous pixel
  always_ff @(posedge clk) begin
    if (acc) begin
      prev_r <= pixel;
      if (first) begin
        il_r   <= il_c;
        fl_r   <= fl_c;
        ir_r   <= ir_c;
        fr_r   <= fr_c;
        lok_r  <= lok_c;
        rok_r  <= rok_c;
        posl_r <= posl_c;
        posr_r <= posr_c;
        fb_r   <= fb_c;
      end
    end
  end

  // stage a: heights and hit flags
  always_ff @(posedge clk) begin
    a_first <= first;
    a_last  <= last_pixel;
    a_hl    <= hit_l;
    a_hf    <= hit_f;
    a_hr    <= hit_r;
    a_sl    <= sl_t[SUM_W-1:0];
    a_sr    <= sr_t[SUM_W-1:0];
    a_sf    <= {1'b0, prev_r} + {1'b0, pixel};
    a_odd   <= {iv, 1'b1};
    a_kl    <= (FRAC_BITS + 1)'(SCALE) - {1'b0, fl_r};
    a_fr    <= fr_r;
    a_posl  <= posl_r;
    a_posr  <= posr_r;
    a_fb    <= fb_row;
  end

  // stage b: areas of the partial terms, full-term weight
  always_ff @(posedge clk) begin
    b_first <= a_first;
    b_last  <= a_last;
    b_hl    <= a_hl;
    b_hf    <= a_hf;
    b_hr    <= a_hr;
    b_al    <= A_W'(a_sl) * A_W'(a_kl);
    b_ar    <= A_W'(a_sr) * A_W'(a_fr);
    b_ff    <= FF_W'(a_sf) * FF_W'(a_odd);
    b_sf    <= a_sf;
    b_posl  <= a_posl;
    b_posr  <= a_posr;
    b_fb    <= a_fb;
  end

  // stage c: moments and areas, gated by hit
  always_ff @(posedge clk) begin
    c_first  <= b_first;
    c_last   <= b_last;
    c_area_l <= b_hl ? b_al : '0;
    c_area_r <= b_hr ? b_ar : '0;
    c_area_f <= b_hf ? (A_W'(b_sf) << (2 * FRAC_BITS)) : '0;
    c_mom_l  <= b_hl ? (ML_W'(b_al) * ML_W'(b_posl)) : '0;
    c_mom_r  <= b_hr ? (ML_W'(b_ar) * ML_W'(b_posr)) : '0;
    c_mom_f  <= b_hf ? (MF_W'(b_ff) << (3 * FRAC_BITS)) : '0;
    c_fb     <= b_fb;
  end

  // stage d: sum of the interval terms
  always_ff @(posedge clk) begin
    d_first <= c_first;
    d_last  <= c_last;
    d_area  <= AREA_W'(c_area_l) + AREA_W'(c_area_r) + AREA_W'(c_area_f);
    d_mom   <= MOM_W'(c_mom_l) + MOM_W'(c_mom_r) + MOM_W'(c_mom_f);
    d_fb    <= c_fb;
  end

  // accumulate, first word of a row restarts the sums
  assign area_nxt = (d_first ? '0 : area_r) + d_area;
  assign mom_nxt  = (d_first ? '0 : mom_r) + d_mom;

  always_ff @(posedge clk) begin
    if (d_v) begin
      area_r <= area_nxt;
      mom_r  <= mom_nxt;
    end
  end

  // hand the finished row to the queue
  assign push = d_v && d_last;
  always_comb begin
    push_job.fb   = d_fb.force_fb || (area_nxt == '0);
    push_job.val  = d_fb.force_fb ? d_fb.fb_val : d_fb.zmid;
    push_job.area = area_nxt;
    push_job.mom  = mom_nxt;
  end

endmodule

/* design/rtc_queue.sv */
// small fifo of finished rows between the accumulator and the divider
module rtc_queue import rtc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rtc_job_t push_job,
  input  logic     pop,
  output logic     empty,
  output rtc_job_t head
);

  rtc_job_t         ent_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign head   = ent_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* design/rtc_back.sv */
// back end: radix-2 restoring divider and output register
module rtc_back import rtc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  rtc_job_t              q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      out_centroid,
  output logic                  out_used
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } st_t;

  st_t                  st_r, st_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [MOM_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]     res_r, res_nxt;
  logic                 used_r, used_nxt;
  logic [DVS_W:0]       shifted;
  logic [DVS_W:0]       diff;
  logic                 ge;
  logic                 load_out;
  logic                 out_valid_r;
  logic [POS_W-1:0]     out_centroid_r;
  logic                 out_used_r;

  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign load_out = (st_r == ST_HOLD) && (!out_valid_r || out_ready);

  // one quotient bit per cycle while in ST_DIV
  assign shifted = {rem_r, quo_r[MOM_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    res_nxt  = res_r;
    used_nxt = used_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.fb) begin
            res_nxt  = q_head.val;
            used_nxt = 1'b1;
            st_nxt   = ST_HOLD;
          end else begin
            rem_nxt = '0;
            dvs_nxt = {q_head.area, 1'b0};
            quo_nxt = q_head.mom;
            cnt_nxt = '0;
            st_nxt  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_nxt = {quo_r[MOM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(MOM_W - 1)) begin
          res_nxt  = quo_nxt[POS_W-1:0];
          used_nxt = 1'b0;
          st_nxt   = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    used_r <= used_nxt;
    if (load_out) begin
      out_centroid_r <= res_r;
      out_used_r     <= used_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_centroid = out_centroid_r;
  assign out_used     = out_used_r;

endmodule

/* design/row_trapezoid_centroid.sv */
// top level of the row trapezoid centroid block
//
// Pixels of one image row stream in on the in_ channel, one word per pixel in
// column order; in_tlast marks the row's last pixel. Row number and the left
// and right subpixel bounds are taken from the row's first word. For every
// row one word leaves on the out_ channel: the centroid column (4 fractional
// bits) in out_tdata and the midpoint-fallback flag in out_tuser.
// The accumulator takes one pixel per cycle while in_tready is high. A row end
// runs through accumulation pipeline stages a, b, c and d into a four-entry row
// queue; the divider then takes an integrated row from the queue, shifts out 48
// quotient bits at one per cycle and hands the result to the output register,
// and hands a fallback row on without dividing. The divider sets the sustained
// pixel rate: while it keeps up with the row ends, one pixel per cycle is taken;
// when it falls behind, the queue fills. in_tready drops only while four row
// ends are waiting for the divider. A stalled receiver holds the output word;
// the divider finishes its row and waits, and the queue keeps taking rows
// behind it. Synchronous reset clears the pipeline, the queue and the output,
// and sets image_width to 2048 and image_height to 1024.
module row_trapezoid_centroid import rtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pixel [7:0], row_index [20:8], left_bound [36:21], right_bound [52:37], zero pad
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // centroid [15:0]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // used_midpoint [0]
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [IMGW_W-1:0] width_r;
  logic [IMGH_W-1:0] height_r;
  logic              push;
  rtc_job_t          push_job;
  logic              q_pop;
  logic              q_empty;
  rtc_job_t          q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMGW_RESET;
      height_r <= IMGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[IMGW_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[IMGH_W-1:0];
        default: begin
          width_r <= width_r;
        end
      endcase
    end
  end

  // accumulation front end
  rtc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel        (in_tdata[7:0]),
    .row_index    (in_tdata[20:8]),
    .left_bound   (in_tdata[36:21]),
    .right_bound  (in_tdata[52:37]),
    .last_pixel   (in_tlast),
    .slot_free    (q_pop),
    .push         (push),
    .push_job     (push_job)
  );

  // finished rows waiting for the divider
  rtc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // divider and output register
  rtc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_centroid (out_tdata),
    .out_used     (out_tuser)
  );

endmodule

/* design/rtc_checker.sv */
// port-level checks for the row trapezoid centroid block, with its bind
module rtc_checker import rtc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  localparam int PEND_MAX = Q_DEPTH + 2;
  localparam int PEND_W   = $clog2(PEND_MAX + 2);

  logic [PEND_W-1:0] pend_r;
  logic              row_in;
  logic              row_out;

  assign row_in  = in_tvalid && in_tready && in_tlast;
  assign row_out = out_tvalid && out_tready;

  // rows accepted whose result word has not been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (row_in && !row_out) begin
      pend_r <= pend_r + 1'b1;
    end else if (!row_in && row_out) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // reset empties the output and frees the input
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output word or stall present after reset");

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // no result word without a finished row behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != '0)
    else $error("result word without a pending row");

  // input backpressure bounds the rows in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(PEND_MAX))
    else $error("too many rows in flight");

endmodule

bind row_trapezoid_centroid rtc_checker u_rtc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/testbench.sv */
// self-checking testbench for the row trapezoid centroid block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rtc_pkg::*;

  localparam int ITEMS      = 1850;
  localparam int CALM_TAIL  = 300;
  localparam int DRAIN_WAIT = 60;
  localparam int CYCLE_CAP  = 600000;

  typedef struct packed {
    logic [POS_W-1:0] centroid;
    logic             used_mid;
  } centroid_t;

  typedef struct {
    logic [PIX_W-1:0] pix;
    int               row;
    int               lb;
    int               rb;
    bit               last;
    bit               typed;
    logic [POS_W-1:0] cen;
    bit               mid;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  row_trapezoid_centroid DUT (.*);

  // predictor state
  int                     img_w = 2048;
  int                     img_h = 1024;
  int                     prev_pix = 0;
  int                     col_cnt = 0;
  logic signed [POS_W-1:0] lat_left = '0;
  logic signed [POS_W-1:0] lat_right = '0;
  bit                     row_ok = 1'b0;
  longint                 area_acc = 0;
  longint                 moment_acc = 0;

  centroid_t want_q[$];
  int        misses = 0;
  int        sent = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  int        stall = 0;
  dir_row_t  plan [24];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // effective row width used for clamping
  function automatic longint row_span();
    longint w;
    w = img_w;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // ordered and clamped stripe bounds
  function automatic void stripe_bounds(output longint lo, output longint hi);
    longint a, b, t, lim;
    a = lat_left;
    b = lat_right;
    lim = (row_span() - 1) * SCALE;
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    if (a < 0) a = 0;
    if (a > lim) a = lim;
    if (b < 0) b = 0;
    if (b > lim) b = lim;
    lo = a;
    hi = b;
  endfunction

  // trapezoid terms for interval i between columns i and i+1
  function automatic void add_interval(longint i, longint p0, longint p1);
    longint lo, hi, il, ir, fl, fr, w, s, a;
    stripe_bounds(lo, hi);
    w = row_span();
    il = lo / SCALE;
    fl = lo - il * SCALE;
    ir = hi / SCALE;
    fr = hi - ir * SCALE;
    // left partial interval
    if (i == il && il < w - 1) begin
      s = p0 * SCALE + (p1 - p0) * fl + p1 * SCALE;
      a = s * (SCALE - fl);
      area_acc += a;
      moment_acc += a * (lo + (il + 1) * SCALE);
    end
    // full intervals
    if (i > il && i < ir) begin
      s = p0 + p1;
      area_acc += s * SCALE * SCALE;
      moment_acc += s * (2 * i + 1) * SCALE * SCALE * SCALE;
    end
    // right partial interval
    if (i == ir && ir < w - 1) begin
      s = p0 * SCALE + p0 * SCALE + (p1 - p0) * fr;
      a = s * fr;
      area_acc += a;
      moment_acc += a * (ir * SCALE + hi);
    end
  endfunction

  // advance the predictor by one pixel; returns 1 when a row result is due
  function automatic bit track_pixel(logic [PIX_W-1:0] pix, logic signed [ROW_W-1:0] row,
                                     logic signed [POS_W-1:0] lb,
                                     logic signed [POS_W-1:0] rb, bit last,
                                     output centroid_t res);
    longint lo, hi, val;
    res.used_mid = 1'b1;
    if (col_cnt == 0) begin
      lat_left = lb;
      lat_right = rb;
      row_ok = (row >= 0) && (row < img_h);
      area_acc = 0;
      moment_acc = 0;
    end else begin
      add_interval(col_cnt - 1, prev_pix, pix);
    end
    prev_pix = pix;
    if (col_cnt < 4095) col_cnt++;
    if (!last) return 1'b0;
    col_cnt = 0;
    if (!row_ok) begin
      val = ((longint'(lat_left) + longint'(lat_right) + 65536) >> 1) - 32768;
    end else begin
      stripe_bounds(lo, hi);
      if (lo == hi) val = lo;
      else if (area_acc == 0) val = (lo + hi) >> 1;
      else begin
        val = moment_acc / (2 * area_acc);
        res.used_mid = 1'b0;
      end
    end
    res.centroid = val[POS_W-1:0];
    return 1'b1;
  endfunction

  function automatic void flag_miss(string what, centroid_t want, centroid_t got);
    misses++;
    if (misses <= 10)
      $display("%s: expected centroid %h mid %0d, got centroid %h mid %0d",
               what, want.centroid, want.used_mid, got.centroid, got.used_mid);
  endfunction

  // result side: check accepted words and drive tready with stall bursts
  always @(posedge clk) begin : result_side
    centroid_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.centroid = out_tdata;
        got.used_mid = out_tuser;
        if (want_q.size() == 0) begin
          flag_miss("unexpected word", '0, got);
        end else begin
          want = want_q.pop_front();
          if (got.centroid !== want.centroid || got.used_mid !== want.used_mid)
            flag_miss("centroid word", want, got);
        end
      end
      if (stall > 0 && !calm) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // send one pixel word, possibly after an idle burst, and predict its result
  task automatic push_pixel(logic [PIX_W-1:0] pix, logic signed [ROW_W-1:0] row,
                            logic signed [POS_W-1:0] lb, logic signed [POS_W-1:0] rb,
                            bit last, bit typed, centroid_t typed_res);
    centroid_t pred;
    int gap;
    calm = (sent >= ITEMS - CALM_TAIL);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, rb, lb, row, pix};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (track_pixel(pix, row, lb, rb, last, pred))
      want_q.insert(want_q.size(), typed ? typed_res : pred);
    sent++;
  endtask

  // let the block go idle before a register write
  task automatic settle();
    in_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write enable stays high here; the caller drops it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) img_w = int'(val[IMGW_W-1:0]);
    else img_h = int'(val[IMGH_W-1:0]);
  endtask

  // one row with random length, bounds and profile
  task automatic random_row(int weff);
    int len, base, span, k0, top;
    logic signed [ROW_W-1:0] row;
    logic signed [POS_W-1:0] lb, rb;
    bit dark;
    base = (weff <= 48) ? weff : $urandom_range(2, 48);
    case ($urandom_range(0, 9))
      0: len = 1;
      1: len = base + $urandom_range(1, 4);
      2: len = base - $urandom_range(0, base - 1);
      default: len = base;
    endcase
    top = (img_h > 4096) ? 4096 : img_h;
    if ($urandom_range(0, 4) != 0 && top > 0) row = ROW_W'($urandom_range(0, top - 1));
    else row = ROW_W'($urandom);
    span = ((len < weff) ? len : weff) * SCALE;
    case ($urandom_range(0, 9))
      0, 1: begin
        lb = POS_W'($urandom);
        rb = POS_W'($urandom);
      end
      2: begin
        lb = POS_W'(int'($urandom_range(0, span + 48)) - 24);
        rb = lb;
      end
      3: begin
        // both bounds inside one pixel interval
        k0 = $urandom_range(0, span / SCALE);
        lb = POS_W'(k0 * SCALE + int'($urandom_range(0, SCALE - 1)));
        rb = POS_W'(k0 * SCALE + int'($urandom_range(0, SCALE - 1)));
      end
      default: begin
        lb = POS_W'(int'($urandom_range(0, span + 48)) - 24);
        rb = POS_W'(int'($urandom_range(0, span + 48)) - 24);
      end
    endcase
    dark = ($urandom_range(0, 6) == 0);
    for (int k = 0; k < len; k++) begin
      // fields past the first pixel are noise the block must ignore
      if (k == 0)
        push_pixel(dark ? 8'd0 : PIX_W'($urandom), row, lb, rb, len == 1, 1'b0, '0);
      else
        push_pixel(dark ? 8'd0 : PIX_W'($urandom), ROW_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom), k == len - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(int w_val, int h_val);
    int rows;
    settle();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
    cfg_we <= 1'b0;
    rows = $urandom_range(6, 14);
    for (int r = 0; r < rows && sent < ITEMS; r++) random_row(int'(row_span()));
  endtask

  // stimulus
  initial begin
    centroid_t typed_res;
    int w_pick, h_pick;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    // directed rows at reset configuration: width 2048, height 1024
    plan = '{
      '{8'd0,   -1,    -32768, 32767,  1, 1, 16'hFFFF, 1}, // row below zero
      '{8'd255, 4095,  32767,  32767,  1, 1, 16'h7FFF, 1}, // row past height
      '{8'd77,  -4096, -32768, -32768, 1, 1, 16'h8000, 1},
      '{8'd128, 1024,  100,    300,    1, 1, 16'd200,  1}, // row equal to height
      '{8'd200, 0,     32,     64,     1, 1, 16'd48,   1}, // single pixel row
      '{8'd9,   1023,  40,     40,     1, 1, 16'd40,   1}, // equal bounds
      '{8'd9,   3,     -100,   -5,     1, 1, 16'd0,    1}, // equal after clamping
      '{8'd0,   2,     0,      64,     0, 0, 16'd0,    0}, // all dark row
      '{8'd0,   2,     0,      64,     0, 0, 16'd0,    0},
      '{8'd0,   2,     0,      64,     0, 0, 16'd0,    0},
      '{8'd0,   2,     0,      64,     0, 0, 16'd0,    0},
      '{8'd0,   2,     0,      64,     1, 1, 16'd32,   1},
      '{8'd0,   1,     16,     48,     0, 0, 16'd0,    0}, // symmetric stripe
      '{8'd255, 1,     16,     48,     0, 0, 16'd0,    0},
      '{8'd255, 1,     16,     48,     0, 0, 16'd0,    0},
      '{8'd0,   1,     16,     48,     1, 0, 16'd0,    0},
      '{8'd255, 7,     40,     8,      0, 0, 16'd0,    0}, // reversed bounds
      '{8'd128, 7,     40,     8,      0, 0, 16'd0,    0},
      '{8'd255, 7,     40,     8,      1, 0, 16'd0,    0},
      '{8'd10,  8,     20,     28,     0, 0, 16'd0,    0}, // bounds in one interval
      '{8'd200, 8,     20,     28,     0, 0, 16'd0,    0},
      '{8'd50,  8,     20,     28,     1, 0, 16'd0,    0},
      '{8'd255, 9,     0,      32767,  0, 0, 16'd0,    0}, // short row, wide bound
      '{8'd1,   9,     0,      32767,  1, 0, 16'd0,    0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (plan[i]) begin
      typed_res.centroid = plan[i].cen;
      typed_res.used_mid = plan[i].mid;
      push_pixel(plan[i].pix, ROW_W'(plan[i].row), POS_W'(plan[i].lb), POS_W'(plan[i].rb),
                 plan[i].last, plan[i].typed, typed_res);
    end
    // register extremes first, then random settings
    run_phase(2, 1);
    run_phase(4095, 4096);
    run_phase(1, 8191);
    run_phase(0, 0);
    run_phase(2048, $urandom_range(1, 4095));
    while (sent < ITEMS) begin
      if (sent >= ITEMS - CALM_TAIL) begin
        // last stretch keeps the settings and sends without pauses
        random_row(int'(row_span()));
      end else begin
        case ($urandom_range(0, 5))
          0: w_pick = 3;
          1, 2, 3: w_pick = $urandom_range(3, 40);
          4: w_pick = $urandom_range(41, 200);
          default: w_pick = $urandom_range(201, 4095);
        endcase
        h_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
        run_phase(w_pick, h_pick);
      end
    end
    in_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (misses == 0 && want_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
